@@ rtl/core/wbpm_pkg.sv @@
package wbpm_pkg;

	// Command codes carried on the opcode field.
	typedef enum logic [2:0] {
		OP_CLEAR   = 3'd0,
		OP_LOAD    = 3'd1,
		OP_FRAME   = 3'd2,
		OP_ACQUIRE = 3'd3,
		OP_RELEASE = 3'd4
	} op_t;

	// Status codes returned with every result.
	typedef enum logic [2:0] {
		STAT_OK          = 3'd0,
		STAT_NO_BUFFER   = 3'd1,
		STAT_BUSY        = 3'd2,
		STAT_BAD_RELEASE = 3'd3,
		STAT_INACTIVE    = 3'd4
	} stat_t;

	// Life cycle of one buffer slot.
	typedef enum logic [2:0] {
		ST_INVALID = 3'd0,
		ST_FREE    = 3'd1,
		ST_WRITING = 3'd2,
		ST_READY   = 3'd3,
		ST_READING = 3'd4
	} sstate_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic [3:0] slot_handle;
		logic       display_active;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        slot_valid;
		logic [3:0]  result_slot;
		logic [31:0] fence_value;
		logic [31:0] completed_count;
	} result_t;

endpackage

@@ rtl/core/writeback_buffer_pool_manager_core.sv @@
// Results: a command taken passes through the input register and then the result register
// to the result ports, marked by done for exactly one cycle.
// Throughput: one command every cycle; busy never rises because the pool update for a
// command completes between the input and result registers.
// Reset: arst_n clears all slot states, both queues, the writing mark, both counters and
// the capture enable at once. The receiver cannot stall; results are never held.
module writeback_buffer_pool_manager_core
	import wbpm_pkg::*;
#(
	parameter int SLOT_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  opcode,
	input  logic [3:0]  slot_handle,
	input  logic        display_active,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	output logic        done,
	output logic [2:0]  status,
	output logic        slot_valid,
	output logic [3:0]  result_slot,
	output logic [31:0] fence_value,
	output logic [31:0] completed_count
);

	// The pool takes a command in every cycle, so the command channel never pushes back.
	// The capture enable is a plain register that accepts every write.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	logic    capture_enabled_q;
	logic    accept;
	item_t   item;
	logic    valid_s1;
	item_t   item_s1;
	result_t res;
	result_t res_s2;
	logic    done_s2;

	assign accept = start && !busy;

	// Field order matches the item layout: opcode, slot handle, display active.
	assign item = {opcode, slot_handle, display_active};

	// Capture enable. The user must change it only while no command is in flight, so
	// the pool sees the value current at issue. The block itself does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_enabled_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			capture_enabled_q <= cfg_data;
		end
	end

	// Stage one: register the command as it arrives.
	wbpm_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// The pool state lives here. The registered command is decoded, the linked queues
	// are updated and the result is formed, all combinationally before the result register,
	// so the next command in stage one always sees the state left by the one before it.
	wbpm_pool #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_pool (
		.clk             (clk),
		.arst_n          (arst_n),
		.valid           (valid_s1),
		.item            (item_s1),
		.capture_enabled (capture_enabled_q),
		.res             (res)
	);

	// Stage two: result register that drives the ports.
	wbpm_out_stage u_out_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid   (valid_s1),
		.res     (res),
		.done_s2 (done_s2),
		.res_s2  (res_s2)
	);

	assign done            = done_s2;
	assign status          = res_s2.status;
	assign slot_valid      = res_s2.slot_valid;
	assign result_slot     = res_s2.result_slot;
	assign fence_value     = res_s2.fence_value;
	assign completed_count = res_s2.completed_count;

	// Every command taken produces exactly one result, flagged by done after the result register.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done)
		else $error("accepted command produced no result");

endmodule

@@ rtl/core/wbpm_in_stage.sv @@
module wbpm_in_stage
	import wbpm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  accept,
	input  item_t item,
	output logic  valid_s1,
	output item_t item_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

endmodule

@@ rtl/core/wbpm_pool.sv @@
module wbpm_pool
	import wbpm_pkg::*;
#(
	parameter int SLOT_COUNT = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    valid,
	input  item_t   item,
	input  logic    capture_enabled,
	output result_t res
);

	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		idx_t head;
		idx_t tail;
		cnt_t count;
	} queue_t;

	sstate_t     st_q   [SLOT_COUNT];
	sstate_t     st_n   [SLOT_COUNT];
	idx_t        nxt_q  [SLOT_COUNT];
	idx_t        nxt_n  [SLOT_COUNT];
	idx_t        prv_q  [SLOT_COUNT];
	idx_t        prv_n  [SLOT_COUNT];
	logic [31:0] fence_q[SLOT_COUNT];

	queue_t      eq_q, eq_n, rq_q, rq_n;
	logic        wv_q, wv_n;
	idx_t        widx_q, widx_n;
	logic [31:0] issued_q, issued_n;
	logic [31:0] fin_q, fin_n;
	logic        fence_we;
	idx_t        fence_slot;

	logic        h_ok;
	idx_t        h_idx;

	assign h_ok  = ({28'd0, item.slot_handle} < 32'(SLOT_COUNT));
	assign h_idx = IDX_W'(item.slot_handle);

	// Each command does at most one unlink followed by at most one append, so the
	// list surgery below is written once and steered by the command decode.
	always_comb begin
		queue_t qw;
		idx_t   p;
		idx_t   n;
		idx_t   s;
		idx_t   un_slot;
		idx_t   push_slot;
		logic   un_en;
		logic   un_rdy;
		logic   push_en;
		logic   push_rdy;
		logic   pick;

		st_n       = st_q;
		nxt_n      = nxt_q;
		prv_n      = prv_q;
		eq_n       = eq_q;
		rq_n       = rq_q;
		wv_n       = wv_q;
		widx_n     = widx_q;
		issued_n   = issued_q;
		fin_n      = fin_q;
		fence_we   = 1'b0;
		fence_slot = '0;
		res        = '0;
		qw         = '0;
		p          = '0;
		n          = '0;
		s          = rq_q.head;
		un_slot    = '0;
		push_slot  = '0;
		un_en      = 1'b0;
		un_rdy     = 1'b0;
		push_en    = 1'b0;
		push_rdy   = 1'b0;
		pick       = 1'b0;

		if (valid) begin
			case (op_t'(item.opcode))
				OP_CLEAR: begin
					if (capture_enabled) begin
						res.status = STAT_BUSY;
					end else begin
						for (int i = 0; i < SLOT_COUNT; i++) begin
							st_n[i] = ST_INVALID;
						end
						eq_n = '0;
						rq_n = '0;
					end
				end
				OP_LOAD: begin
					if (capture_enabled) begin
						res.status = STAT_BUSY;
					end else if (h_ok) begin
						un_slot = h_idx;
						if (st_q[h_idx] == ST_FREE) begin
							un_en = 1'b1;
						end else if (st_q[h_idx] == ST_WRITING || st_q[h_idx] == ST_READY) begin
							un_en  = 1'b1;
							un_rdy = 1'b1;
						end
						st_n[h_idx] = ST_FREE;
						push_en     = 1'b1;
						push_slot   = h_idx;
					end
				end
				OP_FRAME: begin
					if (!item.display_active) begin
						res.status = STAT_INACTIVE;
					end else begin
						if (wv_q) begin
							if (st_q[widx_q] == ST_WRITING) begin
								st_n[widx_q] = ST_READY;
							end
							fin_n = fin_q + 32'd1;
							wv_n  = 1'b0;
						end
						if (capture_enabled) begin
							if (eq_q.count != '0) begin
								s    = eq_q.head;
								pick = 1'b1;
							end else if (rq_q.count >= CNT_W'(2)) begin
								s      = rq_q.head;
								un_rdy = 1'b1;
								pick   = 1'b1;
							end else begin
								res.status = STAT_NO_BUFFER;
							end
							if (pick) begin
								un_en           = 1'b1;
								un_slot         = s;
								issued_n        = issued_q + 32'd1;
								wv_n            = 1'b1;
								widx_n          = s;
								fence_we        = 1'b1;
								fence_slot      = s;
								st_n[s]         = ST_WRITING;
								push_en         = 1'b1;
								push_rdy        = 1'b1;
								push_slot       = s;
								res.slot_valid  = 1'b1;
								res.result_slot = 4'(s);
								res.fence_value = issued_n;
							end
						end
					end
				end
				OP_ACQUIRE: begin
					if (rq_q.count == '0) begin
						res.status = STAT_NO_BUFFER;
					end else begin
						un_en           = 1'b1;
						un_rdy          = 1'b1;
						un_slot         = s;
						st_n[s]         = ST_READING;
						res.slot_valid  = 1'b1;
						res.result_slot = 4'(s);
						res.fence_value = fence_q[s];
					end
				end
				OP_RELEASE: begin
					if (!h_ok || st_q[h_idx] != ST_READING) begin
						res.status = STAT_BAD_RELEASE;
					end else begin
						st_n[h_idx] = ST_FREE;
						push_en     = 1'b1;
						push_slot   = h_idx;
					end
				end
				default: begin
				end
			endcase
		end

		// Take the slot out of its doubly linked queue.
		if (un_en) begin
			qw = un_rdy ? rq_n : eq_n;
			if (qw.count != '0) begin
				p = prv_q[un_slot];
				n = nxt_q[un_slot];
				if (qw.head == un_slot) begin
					qw.head = n;
				end else begin
					nxt_n[p] = n;
				end
				if (qw.tail == un_slot) begin
					qw.tail = p;
				end else begin
					prv_n[n] = p;
				end
				qw.count = qw.count - cnt_t'(1);
			end
			if (un_rdy) begin
				rq_n = qw;
			end else begin
				eq_n = qw;
			end
		end

		// Append the slot at the tail of the target queue.
		if (push_en) begin
			qw = push_rdy ? rq_n : eq_n;
			if (qw.count == '0) begin
				qw.head = push_slot;
			end else begin
				nxt_n[qw.tail]   = push_slot;
				prv_n[push_slot] = qw.tail;
			end
			qw.tail  = push_slot;
			qw.count = qw.count + cnt_t'(1);
			if (push_rdy) begin
				rq_n = qw;
			end else begin
				eq_n = qw;
			end
		end

		res.completed_count = fin_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				st_q[i] <= ST_INVALID;
			end
			eq_q     <= '0;
			rq_q     <= '0;
			wv_q     <= 1'b0;
			widx_q   <= '0;
			issued_q <= '0;
			fin_q    <= '0;
		end else begin
			st_q     <= st_n;
			eq_q     <= eq_n;
			rq_q     <= rq_n;
			wv_q     <= wv_n;
			widx_q   <= widx_n;
			issued_q <= issued_n;
			fin_q    <= fin_n;
		end
	end

	always_ff @(posedge clk) begin
		nxt_q <= nxt_n;
		prv_q <= prv_n;
		if (fence_we) begin
			fence_q[fence_slot] <= issued_n;
		end
	end

	logic [SLOT_COUNT-1:0] in_ready_vec;
	logic [SLOT_COUNT-1:0] in_free_vec;

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			in_ready_vec[i] = (st_q[i] == ST_WRITING) || (st_q[i] == ST_READY);
			in_free_vec[i]  = (st_q[i] == ST_FREE);
		end
	end

	a_ready_members: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(in_ready_vec) == int'(rq_q.count))
		else $error("ready queue length disagrees with slot states");

	a_free_members: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(in_free_vec) == int'(eq_q.count))
		else $error("empty queue length disagrees with slot states");

	a_fin_step: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q == $past(fin_q) || fin_q == $past(fin_q) + 32'd1)
		else $error("completed counter moved by more than one");

endmodule

@@ rtl/core/wbpm_out_stage.sv @@
module wbpm_out_stage
	import wbpm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    valid,
	input  result_t res,
	output logic    done_s2,
	output result_t res_s2
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (valid) begin
			res_s2 <= res;
		end
	end

endmodule
